// ===== sv/sdlpi_pkg.sv =====
// Shared types, constants and bit-order helpers for the lamp and display port interface.
package sdlpi_pkg;

	typedef enum logic [1:0] {
		CMD_PORT_A = 2'd0,
		CMD_PORT_B = 2'd1,
		CMD_PORT_C = 2'd2,
		CMD_TICK   = 2'd3
	} cmd_t;

	localparam logic [7:0]  COLUMN_MASK   = 8'h3f;
	localparam logic [7:0]  SOLENOID_XOR  = 8'hc8;
	localparam logic [7:0]  FAULT_VALUE   = 8'h0a;
	localparam logic [7:0]  IRQ_BIT_MASK  = 8'h20;
	localparam logic [7:0]  LAMP4_MASK    = 8'h10;
	localparam logic [7:0]  LOW_NIBBLE    = 8'h0f;
	localparam int unsigned STROBE_BIT    = 12;
	localparam int unsigned LATCH_BITS    = 32;
	localparam int unsigned DISPLAY_BITS  = 16;

	function automatic logic [7:0] flip8(input logic [7:0] v);
		logic [7:0] r;
		for (int i = 0; i < 8; i++) begin
			r[i] = v[7-i];
		end
		return r;
	endfunction

	function automatic logic [3:0] flip4(input logic [3:0] v);
		return {v[0], v[1], v[2], v[3]};
	endfunction

endpackage

// ===== sv/serial_display_lamp_port_interface.sv =====
// Top level of the output-board port interface: input stage, port decode and result register.
//
// Usage: one transaction on the input channel carries a command (port A, B or C write,
// or frame tick) and a data byte. Every input transaction yields exactly one result
// transaction on the output channel, in order.
// Port A picks the switch column and clears the bit counter; port B sets the solenoid
// byte; port C shifts one inverted bit into the 32-bit latch and, once enough bits are
// in, reports four display digits (columns 1 and 2) or four lamp rows (column 3).
// The input register feeds the decode logic, which loads the result register once the
// item advances, and the result register drives the output port.
// Throughput: one transaction per cycle while the receiver does not stall, set by the single
// decode/update stage that reads and writes the state registers in the same cycle.
// Reset (arst_n low) clears all state and the valid flags of the input stage and the output;
// after release in_stall is low, so the block accepts a transaction.
// When the receiver stalls, the result register holds; the input register still takes
// one more transaction, after which in_stall rises until the output moves on.
// in_stall depends combinationally on out_stall.
module serial_display_lamp_port_interface
	import sdlpi_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic [7:0]  data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [2:0]  switch_column,
	output logic [7:0]  solenoid_bits,
	output logic        display_valid,
	output logic [3:0]  display_slot,
	output logic [15:0] display_digits,
	output logic        lamp_valid,
	output logic [31:0] lamp_rows,
	output logic [7:0]  lamp_row_four,
	output logic        fault_flag,
	output logic        timer_interrupt
);

	// input stage
	logic       valid_s1;
	cmd_t       cmd_s1;
	logic [7:0] data_s1;

	// block state
	logic [2:0]  column_select_q;
	logic [5:0]  bit_count_q;
	logic [31:0] shift_latch_q;
	logic [7:0]  prev_port_c_q;
	logic [1:0]  tick_count_q;
	logic [7:0]  extra_lamp_q;
	logic [7:0]  solenoid_q;
	logic        irq_q;

	// result register
	logic        out_valid_q;
	logic        disp_valid_q;
	logic [3:0]  disp_slot_q;
	logic [15:0] disp_digits_q;
	logic        lamp_valid_q;
	logic [31:0] lamp_rows_q;
	logic        fault_q;

	// next-state and result logic
	logic [2:0]  column_select_d;
	logic [5:0]  bit_count_d;
	logic [31:0] shift_latch_d;
	logic [7:0]  prev_port_c_d;
	logic [1:0]  tick_count_d;
	logic [7:0]  extra_lamp_d;
	logic [7:0]  solenoid_d;
	logic        irq_d;
	logic        disp_valid_d;
	logic [3:0]  disp_slot_d;
	logic [15:0] disp_digits_d;
	logic        lamp_valid_d;
	logic [31:0] lamp_rows_d;
	logic        fault_d;
	logic [1:0]  port_c_col;
	logic [7:0]  col_bits;

	logic advance;
	logic in_accept;

	// The item in the input stage moves on whenever the result register is free or leaving.
	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign in_accept = in_valid && !in_stall;

	always_comb begin
		column_select_d = column_select_q;
		bit_count_d     = bit_count_q;
		shift_latch_d   = shift_latch_q;
		prev_port_c_d   = prev_port_c_q;
		tick_count_d    = tick_count_q;
		extra_lamp_d    = extra_lamp_q;
		solenoid_d      = solenoid_q;
		irq_d           = irq_q;
		disp_valid_d    = 1'b0;
		disp_slot_d     = '0;
		disp_digits_d   = '0;
		lamp_valid_d    = 1'b0;
		lamp_rows_d     = '0;
		fault_d         = 1'b0;
		port_c_col      = 2'd0;
		col_bits        = COLUMN_MASK & ~data_s1;

		case (cmd_s1)
			CMD_PORT_A: begin
				bit_count_d = '0;
				// lowest active-low column bit wins
				column_select_d = 3'd0;
				for (int i = 5; i >= 0; i--) begin
					if (col_bits[i]) begin
						column_select_d = 3'(i + 1);
					end
				end
				if ((data_s1 & LOW_NIBBLE) == 8'h00) begin
					extra_lamp_d[7] = data_s1[7];
				end
				fault_d = (data_s1 == FAULT_VALUE);
			end
			CMD_PORT_B: begin
				solenoid_d = flip8(data_s1 ^ SOLENOID_XOR);
			end
			CMD_PORT_C: begin
				if (!data_s1[1]) begin
					port_c_col = 2'd1;
				end else if (!data_s1[2]) begin
					port_c_col = 2'd2;
				end else if (!data_s1[3]) begin
					port_c_col = 2'd3;
				end
				if (port_c_col != 2'd0) begin
					// counter saturates at 32; a full counter writes nothing
					if (!bit_count_q[5]) begin
						shift_latch_d[bit_count_q[4:0]] = ~data_s1[0];
						bit_count_d = bit_count_q + 6'd1;
					end
					if (port_c_col != 2'd3) begin
						if (bit_count_d >= 6'(DISPLAY_BITS)) begin
							disp_valid_d = 1'b1;
							disp_slot_d  = {(port_c_col == 2'd1), 2'b00,
								shift_latch_d[STROBE_BIT]};
							for (int k = 0; k < 4; k++) begin
								disp_digits_d[4*k +: 4] = flip4(shift_latch_d[4*k +: 4]);
							end
						end
					end else if (bit_count_d >= 6'(LATCH_BITS)) begin
						lamp_valid_d = 1'b1;
						for (int k = 0; k < 4; k++) begin
							lamp_rows_d[8*k +: 8] = flip8(shift_latch_d[8*k +: 8]);
						end
					end
				end
				irq_d         = |(~prev_port_c_q & data_s1 & IRQ_BIT_MASK);
				prev_port_c_d = data_s1;
				if ((data_s1 & LAMP4_MASK) == 8'h00) begin
					tick_count_d    = 2'd0;
					extra_lamp_d[4] = 1'b1;
				end
			end
			CMD_TICK: begin
				tick_count_d = tick_count_q + 2'd1;
				if (tick_count_d == 2'd0) begin
					extra_lamp_d[4] = 1'b0;
				end
			end
			default: begin
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_s1  <= cmd_t'(command);
			data_s1 <= data;
		end
	end

	// state and result register, all loaded when the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_select_q <= '0;
			bit_count_q     <= '0;
			shift_latch_q   <= '0;
			prev_port_c_q   <= '0;
			tick_count_q    <= '0;
			extra_lamp_q    <= '0;
			solenoid_q      <= '0;
			irq_q           <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			if (advance) begin
				column_select_q <= column_select_d;
				bit_count_q     <= bit_count_d;
				shift_latch_q   <= shift_latch_d;
				prev_port_c_q   <= prev_port_c_d;
				tick_count_q    <= tick_count_d;
				extra_lamp_q    <= extra_lamp_d;
				solenoid_q      <= solenoid_d;
				irq_q           <= irq_d;
				out_valid_q     <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			disp_valid_q  <= disp_valid_d;
			disp_slot_q   <= disp_slot_d;
			disp_digits_q <= disp_digits_d;
			lamp_valid_q  <= lamp_valid_d;
			lamp_rows_q   <= lamp_rows_d;
			fault_q       <= fault_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign switch_column   = column_select_q;
	assign solenoid_bits   = solenoid_q;
	assign display_valid   = disp_valid_q;
	assign display_slot    = disp_slot_q;
	assign display_digits  = disp_digits_q;
	assign lamp_valid      = lamp_valid_q;
	assign lamp_rows       = lamp_rows_q;
	assign lamp_row_four   = extra_lamp_q;
	assign fault_flag      = fault_q;
	assign timer_interrupt = irq_q;

endmodule

// ===== sv/sdlpi_checker.sv =====
// Port-level checker for the lamp and display port interface, bound to the top level.
module sdlpi_checker
	import sdlpi_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic [1:0]  command,
	input logic [7:0]  data,
	input logic        out_valid,
	input logic        out_stall,
	input logic [2:0]  switch_column,
	input logic [7:0]  solenoid_bits,
	input logic        display_valid,
	input logic [3:0]  display_slot,
	input logic [15:0] display_digits,
	input logic        lamp_valid,
	input logic [31:0] lamp_rows,
	input logic [7:0]  lamp_row_four,
	input logic        fault_flag,
	input logic        timer_interrupt
);

	// a stalled result transaction stays
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result transaction dropped while stalled");

	// one transaction never completes both a digit group and a lamp update
	a_one_kind: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(display_valid && lamp_valid))
		else $error("display and lamp reported together");

	// digit fields are cleared when no digit group is reported
	a_disp_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !display_valid |-> display_slot == 4'd0 && display_digits == 16'd0)
		else $error("display fields set without display_valid");

	// the fault value has bit 0 low, so it selects switch column one
	a_fault_col: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fault_flag |-> switch_column == 3'd1 && !lamp_valid)
		else $error("fault transaction with wrong column");

endmodule

bind serial_display_lamp_port_interface sdlpi_checker u_sdlpi_checker (.*);
